// File: hdl/crlq_pkg.sv
package crlq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_WIDTH   = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CREDIT_W    = 16;
  localparam int unsigned MAXQ_W      = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUED    = 1'b1;

  localparam logic [CREDIT_W-1:0] MAX_IN_FLIGHT_RST = 16'd4;
  localparam logic [MAXQ_W-1:0]   MAX_QUEUED_RST    = 5'd16;

  typedef enum logic [1:0] {
    OP_POST   = 2'd0,
    OP_FINISH = 2'd1,
    OP_RETRY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    OUTC_ACCEPTED   = 2'd0,
    OUTC_OVERLOADED = 2'd1,
    OUTC_ERROR      = 2'd2
  } outcome_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    fifo_cmd_t fifo;
    logic      issue;
    logic      finish;
    logic      queued;
    logic      dropped;
    logic      from_head;
  } decision_t;

endpackage

// File: hdl/crlq_fifo.sv
module crlq_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  crlq_pkg::fifo_cmd_t                cmd_i,
  input  logic [crlq_pkg::TAG_WIDTH-1:0]     push_tag_i,
  input  logic [crlq_pkg::MAXQ_W-1:0]        max_queued_i,
  output logic [crlq_pkg::TAG_WIDTH-1:0]     head_tag_o,
  output logic [crlq_pkg::CNT_W-1:0]         count_o,
  output crlq_pkg::fifo_stat_t               stat_o
);

  logic [crlq_pkg::TAG_WIDTH-1:0] mem_q [crlq_pkg::QUEUE_DEPTH];
  logic [crlq_pkg::PTR_W-1:0]     head_q, head_d;
  logic [crlq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [crlq_pkg::PTR_W-1:0]     tail;
  logic [crlq_pkg::CNT_W-1:0]     cap;
  logic [crlq_pkg::CNT_W:0]       maxq_ext;

  assign maxq_ext = (crlq_pkg::CNT_W + 1)'(max_queued_i);
  assign cap = (maxq_ext < (crlq_pkg::CNT_W + 1)'(crlq_pkg::QUEUE_DEPTH))
             ? maxq_ext[crlq_pkg::CNT_W-1:0]
             : crlq_pkg::CNT_W'(crlq_pkg::QUEUE_DEPTH);

  assign tail         = head_q + count_q[crlq_pkg::PTR_W-1:0];
  assign head_tag_o   = mem_q[head_q];
  assign count_o      = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q >= cap);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + crlq_pkg::CNT_W'(1);
    end else if (cmd_i.pop) begin
      head_d  = head_q + crlq_pkg::PTR_W'(1);
      count_d = count_q - crlq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail] <= push_tag_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= crlq_pkg::CNT_W'(crlq_pkg::QUEUE_DEPTH))
    else $error("FIFO count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.pop))
    else $error("FIFO push and pop in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("FIFO pop while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> head_q == $past(head_q) + crlq_pkg::PTR_W'(1))
    else $error("FIFO head did not advance after pop");

endmodule

// File: hdl/crlq_decide.sv
module crlq_decide (
  input  crlq_pkg::op_e        op_i,
  input  crlq_pkg::outcome_e   outcome_i,
  input  logic                 has_credit_i,
  input  crlq_pkg::fifo_stat_t fifo_stat_i,
  output crlq_pkg::decision_t  dec_o
);

  always_comb begin
    dec_o = '0;
    unique case (op_i)
      crlq_pkg::OP_POST: begin
        if (has_credit_i && (outcome_i == crlq_pkg::OUTC_ACCEPTED)) begin
          dec_o.issue = 1'b1;
        end else if (!has_credit_i || (outcome_i == crlq_pkg::OUTC_OVERLOADED)) begin
          if (!fifo_stat_i.full) begin
            dec_o.fifo.push = 1'b1;
            dec_o.queued    = 1'b1;
          end else begin
            dec_o.dropped = 1'b1;
          end
        end else begin
          dec_o.dropped = 1'b1;
        end
      end
      crlq_pkg::OP_FINISH: begin
        dec_o.finish = 1'b1;
      end
      crlq_pkg::OP_RETRY: begin
        if (!fifo_stat_i.empty && has_credit_i) begin
          dec_o.fifo.pop = 1'b1;
          if (outcome_i == crlq_pkg::OUTC_ACCEPTED) begin
            dec_o.issue     = 1'b1;
            dec_o.from_head = 1'b1;
          end else begin
            dec_o.dropped = 1'b1;
          end
        end
      end
      default: begin
        dec_o = '0;
      end
    endcase
  end

endmodule

// File: hdl/credit_limited_request_queue.sv
// Credit-limited request queue.
// Input transactions (in_valid_i / in_stall_o) carry an operation: post a
// request tag, report a finished request, or retry the head of the waiting
// queue. Posts carry the downstream outcome of the attempt in the same
// transaction. Each input transaction yields exactly one result transaction
// (out_valid_o / out_stall_i) with the issue, queue and drop flags and the
// counts after the step.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the credit
// limit at index 0 and the queue limit at index 1; it is always ready and is
// meant to be written only while no transaction is in progress.
// A transaction is captured in an input register and its result is computed
// and stored in the output register once the output register is empty or
// its result is taken. One transaction is accepted every cycle while the
// result side keeps up; this rate is set by the single pass from the input
// register through the credit check and FIFO update to the output register.
// When the receiver stalls, the result holds, one more transaction is kept in
// the input register, and then in_stall_o rises.
// Reset clears the in-flight counter, the FIFO head pointer and count, and both
// valid flags, and loads a credit limit of 4 and a queue limit of 16.
module credit_limited_request_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crlq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [crlq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [crlq_pkg::TAG_WIDTH-1:0]      request_tag_i,
  input  logic [1:0]                          post_outcome_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                issued_o,
  output logic [crlq_pkg::TAG_WIDTH-1:0]      issued_tag_o,
  output logic                                queued_o,
  output logic                                dropped_o,
  output logic [crlq_pkg::CREDIT_W-1:0]       in_flight_count_o,
  output logic [crlq_pkg::CNT_W-1:0]          queue_count_o,
  output logic                                retry_pending_o
);

  logic [crlq_pkg::CREDIT_W-1:0]  max_in_flight_q;
  logic [crlq_pkg::MAXQ_W-1:0]    max_queued_q;

  logic                           in_vld_q;
  logic [1:0]                     op_q;
  logic [crlq_pkg::TAG_WIDTH-1:0] tag_q;
  logic [1:0]                     outc_q;

  logic [crlq_pkg::CREDIT_W-1:0]  outstanding_q, outstanding_d;

  logic                           out_vld_q;
  logic                           issued_q, queued_q, dropped_q, pending_q;
  logic [crlq_pkg::TAG_WIDTH-1:0] issued_tag_q, issued_tag_d;
  logic [crlq_pkg::CREDIT_W-1:0]  in_flight_q;
  logic [crlq_pkg::CNT_W-1:0]     qcount_q, qcount_d;

  logic                           accept, advance, fire, has_credit;
  crlq_pkg::decision_t            dec;
  crlq_pkg::fifo_cmd_t            fifo_cmd;
  crlq_pkg::fifo_stat_t           fifo_stat;
  logic [crlq_pkg::TAG_WIDTH-1:0] head_tag;
  logic [crlq_pkg::CNT_W-1:0]     fifo_count;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_vld_q || !out_stall_i;
  assign fire        = in_vld_q && advance;
  assign in_stall_o  = in_vld_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign has_credit  = outstanding_q < max_in_flight_q;

  crlq_decide u_decide (
    .op_i         (crlq_pkg::op_e'(op_q)),
    .outcome_i    (crlq_pkg::outcome_e'(outc_q)),
    .has_credit_i (has_credit),
    .fifo_stat_i  (fifo_stat),
    .dec_o        (dec)
  );

  assign fifo_cmd.push = fire && dec.fifo.push;
  assign fifo_cmd.pop  = fire && dec.fifo.pop;

  crlq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (fifo_cmd),
    .push_tag_i   (tag_q),
    .max_queued_i (max_queued_q),
    .head_tag_o   (head_tag),
    .count_o      (fifo_count),
    .stat_o       (fifo_stat)
  );

  always_comb begin
    outstanding_d = outstanding_q;
    if (dec.issue) begin
      outstanding_d = outstanding_q + crlq_pkg::CREDIT_W'(1);
    end else if (dec.finish && (outstanding_q != '0)) begin
      outstanding_d = outstanding_q - crlq_pkg::CREDIT_W'(1);
    end
    qcount_d = fifo_count;
    if (dec.fifo.push) begin
      qcount_d = fifo_count + crlq_pkg::CNT_W'(1);
    end else if (dec.fifo.pop) begin
      qcount_d = fifo_count - crlq_pkg::CNT_W'(1);
    end
    issued_tag_d = '0;
    if (dec.issue) begin
      issued_tag_d = dec.from_head ? head_tag : tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_in_flight_q <= crlq_pkg::MAX_IN_FLIGHT_RST;
      max_queued_q    <= crlq_pkg::MAX_QUEUED_RST;
      in_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      outstanding_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_i)
          crlq_pkg::CFG_MAX_IN_FLIGHT: begin
            max_in_flight_q <= cfg_data_i;
          end
          crlq_pkg::CFG_MAX_QUEUED: begin
            max_queued_q <= cfg_data_i[crlq_pkg::MAXQ_W-1:0];
          end
          default: begin
            max_queued_q <= max_queued_q;
          end
        endcase
      end
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q     <= 1'b1;
        outstanding_q <= outstanding_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      tag_q  <= request_tag_i;
      outc_q <= post_outcome_i;
    end
    if (fire) begin
      issued_q     <= dec.issue;
      issued_tag_q <= issued_tag_d;
      queued_q     <= dec.queued;
      dropped_q    <= dec.dropped;
      in_flight_q  <= outstanding_d;
      qcount_q     <= qcount_d;
      pending_q    <= (qcount_d != '0) && (outstanding_d < max_in_flight_q);
    end
  end

  assign out_valid_o       = out_vld_q;
  assign issued_o          = issued_q;
  assign issued_tag_o      = issued_tag_q;
  assign queued_o          = queued_q;
  assign dropped_o         = dropped_q;
  assign in_flight_count_o = in_flight_q;
  assign queue_count_o     = qcount_q;
  assign retry_pending_o   = pending_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q && (in_flight_q == outstanding_q))
    else $error("Reported in-flight count differs from the counter");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> qcount_q == fifo_count)
    else $error("Reported queue count differs from the FIFO");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !((dec.issue && dec.dropped) || (dec.issue && dec.queued)
               || (dec.queued && dec.dropped)))
    else $error("More than one disposition for one transaction");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned NUM_DIRECTED = 20;

  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam logic [1:0] OUTC_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                           issued;
    logic [crlq_pkg::TAG_WIDTH-1:0] issued_tag;
    logic                           queued;
    logic                           dropped;
    logic [crlq_pkg::CREDIT_W-1:0]  in_flight;
    logic [crlq_pkg::CNT_W-1:0]     queue_count;
    logic                           retry_pending;
  } status_t;

  typedef struct packed {
    logic [1:0]                     op;
    logic [crlq_pkg::TAG_WIDTH-1:0] tag;
    logic [1:0]                     outc;
    logic                           typed;
    status_t                        res;
  } step_row_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_valid_i    = 1'b0;
  logic                            cfg_ready_o;
  logic [crlq_pkg::CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [crlq_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_stall_o;
  logic [1:0]                      operation_i    = 2'd0;
  logic [crlq_pkg::TAG_WIDTH-1:0]  request_tag_i  = '0;
  logic [1:0]                      post_outcome_i = 2'd0;
  logic                            out_valid_o;
  logic                            out_stall_i    = 1'b0;
  logic                            issued_o;
  logic [crlq_pkg::TAG_WIDTH-1:0]  issued_tag_o;
  logic                            queued_o;
  logic                            dropped_o;
  logic [crlq_pkg::CREDIT_W-1:0]   in_flight_count_o;
  logic [crlq_pkg::CNT_W-1:0]      queue_count_o;
  logic                            retry_pending_o;

  credit_limited_request_queue u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .request_tag_i    (request_tag_i),
    .post_outcome_i   (post_outcome_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .issued_o         (issued_o),
    .issued_tag_o     (issued_tag_o),
    .queued_o         (queued_o),
    .dropped_o        (dropped_o),
    .in_flight_count_o(in_flight_count_o),
    .queue_count_o    (queue_count_o),
    .retry_pending_o  (retry_pending_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  logic [crlq_pkg::TAG_WIDTH-1:0] waiting_tags [crlq_pkg::QUEUE_DEPTH];
  logic [crlq_pkg::PTR_W-1:0]     wait_head;
  logic [crlq_pkg::CNT_W-1:0]     wait_cnt;
  logic [crlq_pkg::CREDIT_W-1:0]  outstanding;
  logic [crlq_pkg::CREDIT_W-1:0]  credit_limit;
  logic [crlq_pkg::MAXQ_W-1:0]    queue_limit;

  status_t     predicted_status [$];
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  bit          idle_en     = 1'b1;
  bit          hold_request = 1'b0;

  step_row_t directed_steps [NUM_DIRECTED] = '{
    '{crlq_pkg::OP_FINISH, 16'h0000, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b0, 16'd0, 5'd0, 1'b0}},
    '{crlq_pkg::OP_RETRY, 16'h0000, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b0, 16'd0, 5'd0, 1'b0}},
    '{OP_UNKNOWN, 16'hFFFF, OUTC_UNKNOWN, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b0, 16'd0, 5'd0, 1'b0}},
    '{crlq_pkg::OP_POST, 16'hFFFF, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b1, 16'hFFFF, 1'b0, 1'b0, 16'd1, 5'd0, 1'b0}},
    '{crlq_pkg::OP_POST, 16'h0000, crlq_pkg::OUTC_OVERLOADED, 1'b1,
      {1'b0, 16'h0000, 1'b1, 1'b0, 16'd1, 5'd1, 1'b1}},
    '{crlq_pkg::OP_POST, 16'h1234, crlq_pkg::OUTC_ERROR, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b1, 16'd1, 5'd1, 1'b1}},
    '{crlq_pkg::OP_POST, 16'h5678, OUTC_UNKNOWN, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b1, 16'd1, 5'd1, 1'b1}},
    '{crlq_pkg::OP_RETRY, 16'hFFFF, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b1, 16'h0000, 1'b0, 1'b0, 16'd2, 5'd0, 1'b0}},
    '{crlq_pkg::OP_POST, 16'hAAAA, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b1, 16'hAAAA, 1'b0, 1'b0, 16'd3, 5'd0, 1'b0}},
    '{crlq_pkg::OP_POST, 16'h5555, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b1, 16'h5555, 1'b0, 1'b0, 16'd4, 5'd0, 1'b0}},
    '{crlq_pkg::OP_POST, 16'h0F0F, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b0, 16'h0000, 1'b1, 1'b0, 16'd4, 5'd1, 1'b0}},
    '{crlq_pkg::OP_RETRY, 16'h0000, crlq_pkg::OUTC_ACCEPTED, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b0, 16'd4, 5'd1, 1'b0}},
    '{crlq_pkg::OP_FINISH, 16'h0000, crlq_pkg::OUTC_ERROR, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b0, 16'd3, 5'd1, 1'b1}},
    '{crlq_pkg::OP_RETRY, 16'h0000, crlq_pkg::OUTC_OVERLOADED, 1'b1,
      {1'b0, 16'h0000, 1'b0, 1'b1, 16'd3, 5'd0, 1'b0}},
    '{crlq_pkg::OP_POST, 16'h8001, crlq_pkg::OUTC_OVERLOADED, 1'b0, '0},
    '{crlq_pkg::OP_POST, 16'h7FFE, crlq_pkg::OUTC_OVERLOADED, 1'b0, '0},
    '{crlq_pkg::OP_RETRY, 16'h0000, crlq_pkg::OUTC_ERROR, 1'b0, '0},
    '{crlq_pkg::OP_RETRY, 16'h0000, OUTC_UNKNOWN, 1'b0, '0},
    '{crlq_pkg::OP_FINISH, 16'h0000, crlq_pkg::OUTC_ACCEPTED, 1'b0, '0},
    '{crlq_pkg::OP_FINISH, 16'h0000, crlq_pkg::OUTC_OVERLOADED, 1'b0, '0}
  };

  int unsigned phase_credit [NUM_PHASES] = '{1, 65535, 3, 2, 0, 65535};
  int unsigned phase_qlimit [NUM_PHASES] = '{1, 16, 5, 16, 0, 1};
  int unsigned phase_items  [NUM_PHASES] = '{120, 140, 140, 150, 150, 130};
  bit          phase_idle   [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic status_t queue_credit_step(input logic [1:0] op,
                                                input logic [crlq_pkg::TAG_WIDTH-1:0] tag,
                                                input logic [1:0] outc);
    status_t                    r;
    logic                       credit;
    logic [crlq_pkg::CNT_W-1:0] cap;
    r = '0;
    credit = outstanding < credit_limit;
    cap = (queue_limit < crlq_pkg::MAXQ_W'(crlq_pkg::QUEUE_DEPTH))
        ? crlq_pkg::CNT_W'(queue_limit) : crlq_pkg::CNT_W'(crlq_pkg::QUEUE_DEPTH);
    case (op)
      crlq_pkg::OP_POST: begin
        if (credit && outc == crlq_pkg::OUTC_ACCEPTED) begin
          outstanding++;
          r.issued = 1'b1;
          r.issued_tag = tag;
        end else if (credit && outc != crlq_pkg::OUTC_OVERLOADED) begin
          r.dropped = 1'b1;
        end else if (wait_cnt < cap) begin
          waiting_tags[crlq_pkg::PTR_W'(wait_head + wait_cnt)] = tag;
          wait_cnt++;
          r.queued = 1'b1;
        end else begin
          r.dropped = 1'b1;
        end
      end
      crlq_pkg::OP_FINISH: begin
        if (outstanding != 0) outstanding--;
      end
      crlq_pkg::OP_RETRY: begin
        if (wait_cnt != 0 && credit) begin
          if (outc == crlq_pkg::OUTC_ACCEPTED) begin
            outstanding++;
            r.issued = 1'b1;
            r.issued_tag = waiting_tags[wait_head];
          end else begin
            r.dropped = 1'b1;
          end
          wait_head++;
          wait_cnt--;
        end
      end
      default: ;
    endcase
    r.in_flight = outstanding;
    r.queue_count = wait_cnt;
    r.retry_pending = (wait_cnt != 0) && (outstanding < credit_limit);
    return r;
  endfunction

  task automatic send_request_op(input logic [1:0] op,
                                 input logic [crlq_pkg::TAG_WIDTH-1:0] tag,
                                 input logic [1:0] outc, input bit typed,
                                 input status_t typed_res);
    int unsigned gap;
    status_t     pred;
    status_t     entry;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    request_tag_i  <= tag;
    post_outcome_i <= outc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = queue_credit_step(op, tag, outc);
    entry = typed ? typed_res : pred;
    predicted_status.insert(predicted_status.size(), entry);
  endtask

  always @(posedge clk_i) begin : result_side
    status_t got;
    status_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {issued_o, issued_tag_o, queued_o, dropped_o, in_flight_count_o,
               queue_count_o, retry_pending_o};
        if (predicted_status.size() == 0) begin
          $error("result transaction with no expectation waiting");
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          if (got.issued !== want.issued) begin
            $error("issued: expected %0h, actual %0h", want.issued, got.issued);
            mismatches++;
          end
          if (got.issued_tag !== want.issued_tag) begin
            $error("issued_tag: expected %0h, actual %0h", want.issued_tag, got.issued_tag);
            mismatches++;
          end
          if (got.queued !== want.queued) begin
            $error("queued: expected %0h, actual %0h", want.queued, got.queued);
            mismatches++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0h, actual %0h", want.dropped, got.dropped);
            mismatches++;
          end
          if (got.in_flight !== want.in_flight) begin
            $error("in_flight_count: expected %0h, actual %0h", want.in_flight, got.in_flight);
            mismatches++;
          end
          if (got.queue_count !== want.queue_count) begin
            $error("queue_count: expected %0h, actual %0h", want.queue_count,
                   got.queue_count);
            mismatches++;
          end
          if (got.retry_pending !== want.retry_pending) begin
            $error("retry_pending: expected %0h, actual %0h", want.retry_pending,
                   got.retry_pending);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = idle_gap();
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned                   ph;
    int unsigned                   k;
    int unsigned                   r;
    logic [1:0]                    op;
    logic [1:0]                    outc;
    logic [crlq_pkg::CREDIT_W-1:0] mif;
    logic [crlq_pkg::MAXQ_W-1:0]   mq;
    outstanding  = '0;
    wait_head    = '0;
    wait_cnt     = '0;
    credit_limit = crlq_pkg::MAX_IN_FLIGHT_RST;
    queue_limit  = crlq_pkg::MAX_QUEUED_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_request_op(directed_steps[k].op, directed_steps[k].tag, directed_steps[k].outc,
                      directed_steps[k].typed, directed_steps[k].res);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      while (predicted_status.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);

      mif = (phase_credit[ph] == 0) ? crlq_pkg::CREDIT_W'($urandom_range(1, 8))
                                    : crlq_pkg::CREDIT_W'(phase_credit[ph]);
      mq  = (phase_qlimit[ph] == 0) ? crlq_pkg::MAXQ_W'($urandom_range(1, 16))
                                    : crlq_pkg::MAXQ_W'(phase_qlimit[ph]);
      cfg_valid_i <= 1'b1;
      cfg_idx_i   <= crlq_pkg::CFG_MAX_IN_FLIGHT;
      cfg_data_i  <= mif;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      credit_limit = mif;
      cfg_idx_i  <= crlq_pkg::CFG_MAX_QUEUED;
      cfg_data_i <= crlq_pkg::CFG_DATA_W'(mq);
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      queue_limit = mq;
      cfg_valid_i <= 1'b0;

      idle_en = phase_idle[ph];
      if (ph == 1) hold_request = 1'b1;

      for (k = 0; k < phase_items[ph]; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50) op = crlq_pkg::OP_POST;
        else if (r < 72) op = crlq_pkg::OP_FINISH;
        else if (r < 96) op = crlq_pkg::OP_RETRY;
        else op = OP_UNKNOWN;
        r = $urandom_range(0, 99);
        if (r < 55) outc = crlq_pkg::OUTC_ACCEPTED;
        else if (r < 78) outc = crlq_pkg::OUTC_OVERLOADED;
        else if (r < 95) outc = crlq_pkg::OUTC_ERROR;
        else outc = OUTC_UNKNOWN;
        send_request_op(op, crlq_pkg::TAG_WIDTH'($urandom), outc, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/crlq_pkg.sv
hdl/crlq_fifo.sv
hdl/crlq_decide.sv
hdl/credit_limited_request_queue.sv
dv/testbench.sv
